// ===== sv/eae_mul_div_shift_unit_defines.svh =====
// Assertion macros for the arithmetic element.
`ifndef EAE_MUL_DIV_SHIFT_UNIT_DEFINES_SVH
`define EAE_MUL_DIV_SHIFT_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define EAE_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define EAE_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define EAE_ASSERT_IMP(label, clk, rst_n, a, c)
`define EAE_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

// ===== sv/eae_pkg.sv =====
// Shared types and constants for the arithmetic element.
package eae_pkg;
  typedef enum logic [2:0] {
    MODE_DIV = 3'd0, MODE_AC = 3'd1, MODE_MQ = 3'd2, MODE_MUL = 3'd3,
    MODE_SCSR = 3'd4, MODE_NOR = 3'd5, MODE_LSH = 3'd6, MODE_ASH = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    KIND_WORD = 2'd0, KIND_LOW = 2'd1, KIND_HIGH = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_NOR, ST_DONE
  } state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;     // capture input item
    logic exec;     // whole non-iterative operation / start of iterative one
    logic div_step;
    logic nor_step;
    logic finish;   // refresh flags, apply failed-divide sign flip, build output
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_div;
    logic is_nor;
    logic div_last;
    logic nor_stop;
  } sts_t;

  localparam logic [7:0] FL_C = 8'h01, FL_NXV = 8'h02, FL_N = 8'h40;
  localparam logic [7:0] FL_Z = 8'h04, FL_MQZ = 8'h08, FL_ACZ = 8'h10;
  localparam logic [7:0] FL_ACM1 = 8'h20, FL_SXT = 8'h80;
  // flags rebuilt from AC and MQ after every write
  localparam logic [7:0] FL_DYN = FL_Z | FL_MQZ | FL_ACZ | FL_ACM1 | FL_SXT;
endpackage

// ===== sv/eae_ctrl.sv =====
// Sequencing controller for the arithmetic element.
module eae_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  eae_pkg::sts_t sts,
  output eae_pkg::cmd_t cmd
);
  import eae_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (sts.is_div) state_nxt = ST_DIV;
        else if (sts.is_nor) state_nxt = ST_NOR;
        else state_nxt = ST_DONE;
      end
      ST_DIV: if (sts.div_last) state_nxt = ST_DONE;
      ST_NOR: if (sts.nor_stop) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (out_valid && !out_ready && state_r == ST_DONE) state_nxt = ST_DONE;
  end

  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (state_r == ST_DONE && !(out_valid_r && !out_ready)) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_EXEC: cmd.exec = 1'b1;
      ST_DIV: cmd.div_step = 1'b1;
      ST_NOR: cmd.nor_step = !sts.nor_stop;
      ST_DONE: cmd.finish = !(out_valid_r && !out_ready);
      default: cmd = '0;
    endcase
  end
endmodule

// ===== sv/eae_dp.sv =====
// Datapath: registers, multiply, shifts, restoring divide, normalize.
module eae_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  eae_pkg::cmd_t        cmd,
  output eae_pkg::sts_t        sts,
  input  logic [2:0]           in_mode,
  input  logic                 in_is_write,
  input  logic [1:0]           in_access_kind,
  input  logic [15:0]          in_write_data,
  output logic [15:0]          out_read_data,
  output logic [15:0]          out_acc_value,
  output logic [15:0]          out_mq_value,
  output logic [15:0]          out_status_word
);
  import eae_pkg::*;

  logic [15:0] ac_r, mq_r;
  logic [7:0]  sr_r, sc_r;
  logic [2:0]  mode_r;
  logic        wr_r;
  logic [1:0]  kind_r;
  logic [15:0] data_r;
  // divide: unsigned restoring on magnitudes
  logic [31:0] rem_r;      // partial remainder: high, remaining dividend bits: low
  logic [15:0] dq_r;
  logic [4:0]  dcnt_r;
  logic        qneg_r, rneg_r, dfail_r;
  logic [15:0] absr_r;
  logic [15:0] rd_r, oac_r, omq_r, osw_r;

  // Data as written, after low byte sign extension.
  logic [15:0] wdata;
  assign wdata = (in_access_kind == KIND_LOW && in_write_data[7]) ?
                 (in_write_data | 16'hFF00) : in_write_data;

  // Signed operands for the execute cycle.
  logic [31:0] dvd, absd;
  logic [15:0] absr;
  logic        dneg;
  assign dvd  = {ac_r, mq_r};
  assign absd = dvd[31] ? (32'd0 - dvd) : dvd;
  assign dneg = data_r[15];
  assign absr = dneg ? (16'd0 - data_r) : data_r;

  logic signed [31:0] prod;
  assign prod = $signed(data_r) * $signed(mq_r);

  // Shift unit.
  logic [5:0]  cnt;
  logic [31:0] sv_out;
  logic [7:0]  sh_fl;
  always_comb begin
    logic [63:0] ext, sl;
    logic [31:0] v, ov;
    logic        neg, ar;
    v = dvd; neg = ac_r[15]; ar = (mode_r == MODE_ASH);
    cnt = data_r[5:0];
    sh_fl = '0; sv_out = v; ext = '0; sl = '0; ov = '0;
    if (cnt != 6'd0) begin
      if (!cnt[5]) begin
        ext = {{32{v[31]}}, v};
        sl = ext << cnt;
        if (ar) begin
          sv_out = {v[31], sl[30:0]};
          ov = sl[62:31];
          if (neg) ov = ov | (32'hFFFFFFFF << cnt);
        end else begin
          sv_out = sl[31:0];
          ov = sl[63:32];
        end
        if (ov != {32{sv_out[31]}}) sh_fl = sh_fl | FL_NXV;
        if (ov[0]) sh_fl = sh_fl | FL_C;
      end else begin
        // right shift by 64-cnt, cnt in 32..63; last bit out is v[63-cnt]
        ext = {((ar && neg) ? 32'hFFFFFFFF : 32'd0), v};
        sl = ext >> (7'd64 - {1'b0, cnt});
        if (v[~cnt[4:0]]) sh_fl = FL_C;
        sv_out = sl[31:0];
      end
    end
  end

  // Normalize stop test.
  logic nstop;
  assign nstop = (ac_r == 16'hC000 && mq_r == 16'd0) || (ac_r[15] ^ ac_r[14]) ||
                 (sc_r == 8'd31);

  // Divide step.
  logic [16:0] trial;
  assign trial = {1'b0, rem_r[30:15]} - {1'b0, absr_r};

  logic dfail_nxt;
  assign dfail_nxt = (absd[31:16] >= absr);

  assign sts.is_div   = wr_r && mode_r == MODE_DIV && !dfail_nxt;
  assign sts.is_nor   = wr_r && mode_r == MODE_NOR;
  assign sts.div_last = (dcnt_r == 5'd15);
  assign sts.nor_stop = nstop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac_r <= '0; mq_r <= '0; sr_r <= '0; sc_r <= '0;
    end else begin
      if (cmd.exec && wr_r) begin
        case (mode_r)
          MODE_DIV: begin
            dfail_r <= dfail_nxt;
            qneg_r <= dvd[31] ^ dneg;
            rneg_r <= dvd[31];
            absr_r <= absr;
            rem_r <= absd;
            dq_r <= '0;
            dcnt_r <= '0;
            if (dfail_nxt) begin
              logic match;
              logic [15:0] a;
              match = ~(ac_r[15] ^ data_r[15]);
              a = {ac_r[14:0], mq_r[15]};
              a = match ? (a - data_r) : (a + data_r);
              ac_r <= a;
              mq_r <= {mq_r[14:0], match};
              sc_r <= 8'd15;
              sr_r <= FL_NXV | ((a[15] ^ data_r[15]) ? 8'd0 : FL_C);
            end
          end
          MODE_AC: ac_r <= data_r;
          MODE_MQ: begin
            mq_r <= data_r;
            ac_r <= {16{data_r[15]}};
          end
          MODE_MUL: begin
            sc_r <= '0;
            ac_r <= prod[31:16];
            mq_r <= prod[15:0];
            sr_r <= prod[31] ? (FL_N | FL_NXV) : 8'd0;
          end
          MODE_SCSR: if (kind_r != KIND_LOW && kind_r != KIND_HIGH) begin
            sr_r <= data_r[15:8] & (FL_N | FL_NXV | FL_C);
            sc_r <= data_r[7:0];
          end
          MODE_NOR: sc_r <= '0;
          default: begin
            sc_r <= '0;
            ac_r <= sv_out[31:16];
            mq_r <= sv_out[15:0];
            sr_r <= sh_fl ^ (sv_out[31] ? (FL_N | FL_NXV) : 8'd0);
          end
        endcase
      end
      if (cmd.div_step) begin
        // one quotient bit a cycle; rem_r[31:16] partial remainder
        dcnt_r <= dcnt_r + 5'd1;
        if (!trial[16]) begin
          rem_r <= {trial[15:0], rem_r[14:0], 1'b0};
          dq_r <= {dq_r[14:0], 1'b1};
        end else begin
          rem_r <= {rem_r[30:0], 1'b0};
          dq_r <= {dq_r[14:0], 1'b0};
        end
        if (sts.div_last) begin
          logic [15:0] q, r;
          logic [15:0] qq;
          qq = !trial[16] ? {dq_r[14:0], 1'b1} : {dq_r[14:0], 1'b0};
          r  = !trial[16] ? trial[15:0] : rem_r[30:15];
          q  = qneg_r ? (16'd0 - qq) : qq;
          mq_r <= q;
          ac_r <= rneg_r ? (16'd0 - r) : r;
          sc_r <= '0;
          // overflow when the magnitude does not fit the signed range
          sr_r <= (((!qneg_r && qq[15]) || (qneg_r && qq > 16'h8000)) ? FL_NXV : 8'd0)
                  ^ (q[15] ? (FL_N | FL_NXV) : 8'd0);
        end
      end
      if (cmd.nor_step) begin
        ac_r <= {ac_r[14:0], mq_r[15]};
        mq_r <= {mq_r[14:0], 1'b0};
        sc_r <= sc_r + 8'd1;
      end
      if (cmd.finish && wr_r) begin
        logic [7:0] f;
        f = sr_r & ~FL_DYN;
        if (mode_r == MODE_NOR) f = ac_r[15] ? (FL_N | FL_NXV) : 8'd0;
        if (mode_r == MODE_DIV && dfail_r) f = f ^ (mq_r[15] ? (FL_N | FL_NXV) : 8'd0);
        if (mq_r == 16'd0) f = f | FL_MQZ;
        if (ac_r == 16'd0) begin
          f = f | FL_ACZ;
          if (!mq_r[15]) f = f | FL_SXT;
          if (mq_r == 16'd0) f = f | FL_Z;
        end
        if (ac_r == 16'hFFFF) begin
          f = f | FL_ACM1;
          if (mq_r[15]) f = f | FL_SXT;
        end
        sr_r <= f;
      end
    end
  end

  // Failure-path flags computed at exec ignore the MQ sign flip, applied at finish.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r <= in_mode; wr_r <= in_is_write; kind_r <= in_access_kind; data_r <= wdata;
    end
    if (cmd.finish) begin
      logic [7:0] fo;
      fo = sr_r;
      oac_r <= ac_r; omq_r <= mq_r;
      rd_r <= '0;
      if (wr_r) begin
        fo = sr_r & ~FL_DYN;
        if (mode_r == MODE_NOR) fo = ac_r[15] ? (FL_N | FL_NXV) : 8'd0;
        if (mode_r == MODE_DIV && dfail_r) fo = fo ^ (mq_r[15] ? (FL_N | FL_NXV) : 8'd0);
        if (mq_r == 16'd0) fo = fo | FL_MQZ;
        if (ac_r == 16'd0) begin
          fo = fo | FL_ACZ;
          if (!mq_r[15]) fo = fo | FL_SXT;
          if (mq_r == 16'd0) fo = fo | FL_Z;
        end
        if (ac_r == 16'hFFFF) begin
          fo = fo | FL_ACM1;
          if (mq_r[15]) fo = fo | FL_SXT;
        end
      end else begin
        case (mode_r)
          MODE_AC:   rd_r <= ac_r;
          MODE_MQ:   rd_r <= mq_r;
          MODE_SCSR: rd_r <= {sr_r, sc_r};
          MODE_NOR:  rd_r <= {8'd0, sc_r};
          default:   rd_r <= '0;
        endcase
      end
      osw_r <= {fo, sc_r};
    end
  end

  assign out_read_data   = rd_r;
  assign out_acc_value   = oac_r;
  assign out_mq_value    = omq_r;
  assign out_status_word = osw_r;
endmodule

// ===== sv/eae_mul_div_shift_unit.sv =====
// Top level of the arithmetic element.
// One register access per transfer, one access in flight at a time. For a read,
// an AC, MQ or SC/SR load, MUL, LSH, ASH and a DIV that fails its range check,
// out_valid rises after the input transfer, by way of the EXEC and DONE states,
// and in_ready returns in the same cycle. Any other DIV write adds the divide
// loop, one quotient bit per cycle. A NOR write adds the normalize loop, one
// shift per cycle until the stop test holds or SC reaches 31. A result waits in
// the output register while the receiver holds off; the next access may run
// meanwhile but stalls at completion until that result is taken.
module eae_mul_div_shift_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_mode,
  input  logic        in_is_write,
  input  logic [1:0]  in_access_kind,
  input  logic [15:0] in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_read_data,
  output logic [15:0] out_acc_value,
  output logic [15:0] out_mq_value,
  output logic [15:0] out_status_word
);
  `include "eae_mul_div_shift_unit_defines.svh"
  import eae_pkg::*;

  cmd_t cmd;
  sts_t sts;

  eae_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .cmd
  );

  eae_dp u_dp (
    .clk, .rst_n, .cmd, .sts, .in_mode, .in_is_write, .in_access_kind, .in_write_data,
    .out_read_data, .out_acc_value, .out_mq_value, .out_status_word
  );

  `EAE_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_acc_value) && $stable(out_mq_value))
  `EAE_ASSERT_IMP(a_one_cmd, clk, rst_n, 1'b1, $onehot0(cmd))
  `EAE_ASSERT_NXT(a_load_exec, clk, rst_n, cmd.load, cmd.exec)
endmodule

// ===== verif/tb_eae_mul_div_shift_unit.sv =====
// Testbench for the arithmetic element: directed and random accesses checked against a predictor.
`timescale 1ns / 100ps

module tb_eae_mul_div_shift_unit;
  import eae_pkg::*;

  typedef struct packed {
    logic [15:0] rd;
    logic [15:0] ac;
    logic [15:0] mq;
    logic [15:0] sw;
  } access_result_t;

  class access_scoreboard;
    logic [15:0] ac, mq;
    logic [7:0] sr, sc;
    access_result_t pending[$];
    int mismatches;
    int checked;

    function new();
      ac = 0; mq = 0; sr = 0; sc = 0;
      mismatches = 0; checked = 0;
    endfunction

    function void refresh();
      sr &= ~FL_DYN;
      if (mq == 0) sr |= FL_MQZ;
      if (ac == 0) begin
        sr |= FL_ACZ;
        if (!mq[15]) sr |= FL_SXT;
        if (mq == 0) sr |= FL_Z;
      end
      if (ac == 16'hFFFF) begin
        sr |= FL_ACM1;
        if (mq[15]) sr |= FL_SXT;
      end
    endfunction

    function void divide(logic [15:0] d);
      logic [31:0] dvd, dvr, absd, absr, a;
      logic match;
      int sd, sv, q, r;
      dvd = {ac, mq};
      dvr = {{16{d[15]}}, d};
      absd = dvd[31] ? -dvd : dvd;
      absr = dvr[31] ? -dvr : dvr;
      sr = 0;
      if ((absd >> 16) >= absr) begin
        match = (ac[15] == d[15]);
        a = {15'd0, ac, mq[15]};
        a = match ? a - dvr : a + dvr;
        ac = a[15:0];
        mq = {mq[14:0], match};
        if (ac[15] == d[15]) sr |= FL_C;
        sc = 15;
        sr |= FL_NXV;
      end else begin
        sd = dvd[31] ? -int'(absd) : int'(absd);
        sv = dvr[31] ? -int'(absr) : int'(absr);
        q = sd / sv;
        r = sd % sv;
        sc = 0;
        mq = q[15:0];
        ac = r[15:0];
        if (q > 32767 || q < -32768) sr |= FL_NXV;
      end
      if (mq[15]) sr ^= (FL_N | FL_NXV);
    endfunction

    function void shift(logic [15:0] d, bit arith);
      logic [5:0] cnt;
      logic [31:0] v, o, r;
      logic neg;
      cnt = d[5:0];
      sc = 0; sr = 0;
      if (cnt != 0) begin
        v = {ac, mq};
        neg = ac[15];
        if (cnt < 32) begin
          if (arith) begin
            o = $signed(v) >>> (31 - cnt);
            if (neg) o |= 32'hFFFFFFFF << cnt;
            v = (v & 32'h80000000) | ((v << cnt) & 32'h7FFFFFFF);
          end else begin
            o = $signed(v) >>> (32 - cnt);
            v = v << cnt;
          end
          if (o != (v[31] ? 32'hFFFFFFFF : 32'h0)) sr |= FL_NXV;
          if (o[0]) sr |= FL_C;
        end else begin
          if (v[63 - cnt]) sr |= FL_C;
          if (cnt == 32) v = (arith && neg) ? 32'hFFFFFFFF : 32'h0;
          else begin
            r = v >> (64 - cnt);
            if (arith && neg) r |= 32'hFFFFFFFF << (cnt - 32);
            v = r;
          end
        end
        ac = v[31:16];
        mq = v[15:0];
      end
      if (ac[15]) sr ^= (FL_N | FL_NXV);
    endfunction

    function void note_access(logic [2:0] md, logic wr, logic [1:0] kind, logic [15:0] d);
      access_result_t e;
      logic [31:0] p;
      int n;
      e.rd = 0;
      if (wr) begin
        if (kind == KIND_LOW && d[7]) d[15:8] = 8'hFF;
        case (mode_t'(md))
          MODE_DIV: divide(d);
          MODE_AC: ac = d;
          MODE_MQ: begin
            mq = d;
            ac = d[15] ? 16'hFFFF : 16'h0;
          end
          MODE_MUL: begin
            p = {{16{d[15]}}, d} * {{16{mq[15]}}, mq};
            sc = 0;
            ac = p[31:16];
            mq = p[15:0];
            sr = ac[15] ? (FL_N | FL_NXV) : 8'h0;
          end
          MODE_SCSR: begin
            if (kind != KIND_LOW && kind != KIND_HIGH) begin
              sr = d[15:8] & (FL_N | FL_NXV | FL_C);
              sc = d[7:0];
            end
          end
          MODE_NOR: begin
            for (n = 0; n < 31; n++) begin
              if ((ac == 16'hC000 && mq == 0) || (ac[15] ^ ac[14])) break;
              ac = {ac[14:0], mq[15]};
              mq = {mq[14:0], 1'b0};
            end
            sc = 8'(n);
            sr = ac[15] ? (FL_N | FL_NXV) : 8'h0;
          end
          MODE_LSH: shift(d, 0);
          default: shift(d, 1);
        endcase
        refresh();
      end else begin
        case (mode_t'(md))
          MODE_AC: e.rd = ac;
          MODE_MQ: e.rd = mq;
          MODE_SCSR: e.rd = {sr, sc};
          MODE_NOR: e.rd = {8'h0, sc};
          default: e.rd = 0;
        endcase
      end
      e.ac = ac; e.mq = mq; e.sw = {sr, sc};
      pending.push_back(e);
    endfunction

    function void check_result(access_result_t got);
      access_result_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (e !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch rd %h/%h ac %h/%h mq %h/%h sw %h/%h (exp/act)",
                   e.rd, got.rd, e.ac, got.ac, e.mq, got.mq, e.sw, got.sw);
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_ready, in_is_write;
  logic [2:0] in_mode;
  logic [1:0] in_access_kind;
  logic [15:0] in_write_data;
  logic out_valid, out_ready;
  logic [15:0] out_read_data, out_acc_value, out_mq_value, out_status_word;

  access_scoreboard sb;
  bit hold_off;
  bit stim_done;

  eae_mul_div_shift_unit dut (.*);

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // drop valid only across a gap, so back-to-back transfers keep it high
  task automatic send_access(logic [2:0] md, logic wr, logic [1:0] kind, logic [15:0] d);
    int g;
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(negedge clk);
    end
    in_valid <= 1;
    in_mode <= md;
    in_is_write <= wr;
    in_access_kind <= kind;
    in_write_data <= d;
    do @(posedge clk); while (!in_ready);
    sb.note_access(md, wr, kind, d);
    @(negedge clk);
  endtask

  task automatic send_random();
    logic [15:0] d;
    logic [2:0] md;
    d = 16'($urandom);
    md = 3'($urandom_range(0, 7));
    case ($urandom_range(0, 5))
      0: d = 16'($urandom_range(0, 3));
      1: d = {$urandom_range(0, 1) ? 8'hFF : 8'h00, 8'($urandom)};
      2: d = 16'h8000 ^ 16'($urandom_range(0, 1));
      default: ;
    endcase
    // shifts mostly with the count field randomized
    send_access(md, $urandom_range(0, 3) != 0, 2'($urandom_range(0, 3)), d);
  endtask

  initial begin
    sb = new();
    rst_n = 0;
    hold_off = 0;
    in_valid = 0; in_mode = 0; in_is_write = 0; in_access_kind = 0; in_write_data = 0;
    stim_done = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);
    // directed: loads, byte writes, reads, MUL, NOR, shifts, divides incl. zero divisor, overflow
    send_access(MODE_AC, 1, KIND_WORD, 16'hFFFF);
    send_access(MODE_MQ, 1, KIND_LOW, 16'h0080);
    send_access(MODE_MQ, 1, KIND_HIGH, 16'h8000);
    send_access(MODE_AC, 0, KIND_WORD, 0);
    send_access(MODE_MQ, 0, KIND_WORD, 0);
    send_access(MODE_SCSR, 1, KIND_WORD, 16'hFFFF);
    send_access(MODE_SCSR, 1, KIND_LOW, 16'h0000);
    send_access(MODE_SCSR, 0, KIND_WORD, 0);
    send_access(MODE_AC, 1, 2'd3, 16'h0000);
    send_access(MODE_MQ, 1, KIND_WORD, 16'h0064);
    send_access(MODE_DIV, 1, KIND_WORD, 16'h0007);
    send_access(MODE_DIV, 1, KIND_WORD, 16'h0000);
    send_access(MODE_AC, 1, KIND_WORD, 16'h7FFF);
    send_access(MODE_DIV, 1, KIND_LOW, 16'h00FF);
    send_access(MODE_MUL, 1, KIND_WORD, 16'h8000);
    send_access(MODE_MUL, 1, KIND_WORD, 16'h7FFF);
    send_access(MODE_AC, 1, KIND_WORD, 16'h0000);
    send_access(MODE_MQ, 1, KIND_WORD, 16'h0001);
    send_access(MODE_NOR, 1, KIND_WORD, 0);
    send_access(MODE_NOR, 0, KIND_WORD, 0);
    send_access(MODE_LSH, 1, KIND_WORD, 16'h0000);
    send_access(MODE_LSH, 1, KIND_WORD, 16'h001F);
    send_access(MODE_ASH, 1, KIND_WORD, 16'h0020);
    send_access(MODE_ASH, 1, KIND_WORD, 16'h003F);
    send_access(MODE_DIV, 0, KIND_WORD, 0);
    fork
      begin
        @(negedge clk);
        hold_off = 1;
        repeat (200) @(posedge clk);
        hold_off = 0;
      end
      repeat (1500) send_random();
    join
    in_valid <= 0;
    stim_done = 1;
  end

  // receiver with random stalls
  initial begin
    int g;
    out_ready = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_ready <= 0;
      else begin
        g = gap_len();
        if (g != 0) begin
          out_ready <= 0;
          repeat (g) @(negedge clk);
        end
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_read_data, out_acc_value, out_mq_value, out_status_word});
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Covered %0d accesses across all eight registers, reads and writes,", sb.checked);
    $display("with random stalls on both channels and one long receiver hold-off.");
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end
endmodule
